// ----- sv/swm_pkg.sv -----
`default_nettype none
package swm_pkg;

	// Flags one cell shows its neighbors each cycle
	typedef struct packed {
		logic ge;   // own entry >= the leaving sample, removal in effect
		logic les;  // own entry <= the new sample
		logic bv;   // own slot lies inside the window after removal
	} swm_flag_t;

endpackage
`default_nettype wire

// ----- sv/swm_cell.sv -----
`default_nettype none
module swm_cell
	import swm_pkg::*;
#(
	parameter int SAMPLE_WIDTH = 32
) (
	input  wire logic                           clk,
	input  wire logic                           en,
	input  wire logic signed [SAMPLE_WIDTH-1:0] s,
	input  wire logic signed [SAMPLE_WIDTH-1:0] v,
	input  wire logic                           rmv,
	input  wire logic                           bv,
	input  wire logic signed [SAMPLE_WIDTH-1:0] prev_val,
	input  wire swm_flag_t                      prev_flg,
	input  wire logic signed [SAMPLE_WIDTH-1:0] next_val,
	input  wire swm_flag_t                      next_flg,
	output logic signed [SAMPLE_WIDTH-1:0]      val,
	output swm_flag_t                           flg
);

	logic signed [SAMPLE_WIDTH-1:0] val_q;
	logic signed [SAMPLE_WIDTH-1:0] b_self;
	logic signed [SAMPLE_WIDTH-1:0] b_prev;
	logic signed [SAMPLE_WIDTH-1:0] nxt;
	logic                           leb_self;
	logic                           leb_prev;

	assign val     = val_q;
	assign flg.ge  = rmv & (val_q >= v);
	assign flg.les = (val_q <= s);
	assign flg.bv  = bv;

	// Entry after removal: close the gap by taking the upper neighbor
	assign b_self   = flg.ge ? next_val : val_q;
	assign leb_self = bv & (flg.ge ? next_flg.les : flg.les);
	assign b_prev   = prev_flg.ge ? val_q : prev_val;
	assign leb_prev = prev_flg.bv & (prev_flg.ge ? flg.les : prev_flg.les);

	// Insert after equal entries: keep, take the new sample, or shift up
	assign nxt = leb_self ? b_self : (leb_prev ? s : b_prev);

	always_ff @(posedge clk) begin
		if (en) begin
			val_q <= nxt;
		end
	end

endmodule
`default_nettype wire

// ----- sv/swm_delay.sv -----
`default_nettype none
module swm_delay #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 32,
	parameter int AW    = 6
) (
	input  wire logic             clk,
	input  wire logic             en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0]      rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_q;

	assign rd_data = rd_q;

	// Write-first: a read of the slot written in the same cycle sees new data
	always_ff @(posedge clk) begin
		if (en) begin
			mem[wr_addr] <= wr_data;
			if (rd_addr == wr_addr) begin
				rd_q <= wr_data;
			end else begin
				rd_q <= mem[rd_addr];
			end
		end
	end

endmodule
`default_nettype wire

// ----- sv/sliding_window_median.sv -----
`default_nettype none
// Running lower median over the last window_size samples.
// An accepted sample updates the sorted cell chain, the delay-line memory and
// the pending flag; the median tap is registered once the output is free.
// Throughput: 1 sample per cycle while in_stall is low.
// Reset: window_size returns to 3, fill count and oldest pointer clear, the
// output empties; sample storage is not cleared and is written before use.
module sliding_window_median
	import swm_pkg::*;
#(
	parameter int WINDOW_MAX   = 64,
	parameter int SAMPLE_WIDTH = 32
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic signed [SAMPLE_WIDTH-1:0] sample,
	input  wire logic                           start_req,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic signed [SAMPLE_WIDTH-1:0]      median,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [6:0]                     window_size
);

	localparam int KW = $clog2(WINDOW_MAX + 1);
	localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

	logic [6:0]    ws_q;
	logic [KW-1:0] fill_q;
	logic [AW-1:0] ptr_q;
	logic          pend_q;
	logic          out_valid_q;
	logic signed [SAMPLE_WIDTH-1:0] median_q;

	logic          accept;
	logic          cfg_wr;
	logic [KW-1:0] k;
	logic [KW-1:0] fill_eff;
	logic [AW-1:0] ptr_eff;
	logic          full;
	logic [KW-1:0] m;
	logic [KW-1:0] ptr_ext;
	logic [AW-1:0] ptr_nxt;
	logic [KW-1:0] fill_nxt;
	logic [AW-1:0] wr_addr;
	logic [KW-1:0] idx;
	logic          load_out;
	logic signed [SAMPLE_WIDTH-1:0] oldest;

	logic signed [SAMPLE_WIDTH-1:0] vals [WINDOW_MAX];
	swm_flag_t                      flgs [WINDOW_MAX];

	// Move a pending median to the output whenever the output is free or drains
	assign load_out  = pend_q & (~out_valid_q | ~out_stall);
	assign in_stall  = pend_q & out_valid_q & out_stall;
	assign accept    = in_valid & ~in_stall;
	assign cfg_ready = ~pend_q & ~out_valid_q;
	assign cfg_wr    = cfg_valid & cfg_ready;
	assign out_valid = out_valid_q;
	assign median    = median_q;

	// Effective window length: zero acts as one, large values saturate
	always_comb begin
		if (ws_q == '0) begin
			k = KW'(1);
		end else if (int'(ws_q) > WINDOW_MAX) begin
			k = KW'(WINDOW_MAX);
		end else begin
			k = KW'(ws_q);
		end
	end

	// A start request empties the window before this sample goes in
	assign fill_eff = start_req ? '0 : fill_q;
	assign ptr_eff  = start_req ? '0 : ptr_q;
	assign full     = (fill_eff >= k);

	// Entries left after the oldest drops out
	assign m = full ? (k - KW'(1)) : fill_eff;

	// Advance the oldest pointer around the ring, hold it at zero while filling
	assign ptr_ext  = KW'(ptr_eff) + KW'(1);
	assign ptr_nxt  = (full && ptr_ext != k) ? ptr_ext[AW-1:0] : '0;
	assign fill_nxt = full ? k : (fill_eff + KW'(1));
	assign wr_addr  = full ? ptr_eff : fill_eff[AW-1:0];

	assign idx = (k - KW'(1)) >> 1;

	// Delay line: prefetch the sample that leaves on the next request
	swm_delay #(
		.DEPTH (WINDOW_MAX),
		.WIDTH (SAMPLE_WIDTH),
		.AW    (AW)
	) u_delay (
		.clk     (clk),
		.en      (accept),
		.wr_addr (wr_addr),
		.wr_data (sample),
		.rd_addr (ptr_nxt),
		.rd_data (oldest)
	);

	// Sorted window: one cell per rank, each talking to its two neighbors
	for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
		logic signed [SAMPLE_WIDTH-1:0] pv;
		logic signed [SAMPLE_WIDTH-1:0] nv;
		swm_flag_t                      pf;
		swm_flag_t                      nf;
		logic                           bv;

		assign bv = (KW'(i) < m);

		if (i == 0) begin : g_lo
			// Below the lowest rank everything counts as not greater
			assign pv = '0;
			assign pf = '{ge: 1'b0, les: 1'b1, bv: 1'b1};
		end else begin : g_mid_lo
			assign pv = vals[i-1];
			assign pf = flgs[i-1];
		end

		if (i == WINDOW_MAX - 1) begin : g_hi
			assign nv = '0;
			assign nf = '{ge: 1'b0, les: 1'b0, bv: 1'b0};
		end else begin : g_mid_hi
			assign nv = vals[i+1];
			assign nf = flgs[i+1];
		end

		swm_cell #(
			.SAMPLE_WIDTH (SAMPLE_WIDTH)
		) u_cell (
			.clk      (clk),
			.en       (accept),
			.s        (sample),
			.v        (oldest),
			.rmv      (full),
			.bv       (bv),
			.prev_val (pv),
			.prev_flg (pf),
			.next_val (nv),
			.next_flg (nf),
			.val      (vals[i]),
			.flg      (flgs[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ws_q        <= 7'd3;
			fill_q      <= '0;
			ptr_q       <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				ws_q   <= window_size;
				fill_q <= '0;
				ptr_q  <= '0;
			end else if (accept) begin
				fill_q <= fill_nxt;
				ptr_q  <= ptr_nxt;
			end

			// A full window after this request owes one median
			if (accept) begin
				pend_q <= (fill_nxt == k);
			end else if (load_out) begin
				pend_q <= 1'b0;
			end

			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Tap the median rank; the cells still hold the pending request's window
	always_ff @(posedge clk) begin
		if (load_out) begin
			median_q <= vals[idx[AW-1:0]];
		end
	end

endmodule
`default_nettype wire
